[src/hmo_pkg.sv]
// ----------------------------------------------------------------------------
// hmo_pkg
// Shared widths, register indexes and helpers for the mirrored offset block.
// ----------------------------------------------------------------------------
package hmo_pkg;

   localparam int DIM_LIMIT    = 3;
   localparam int NUM_DIMS_DEF = 3;
   localparam int INDEX_W      = 48;
   localparam int SIZE_W       = 17;
   localparam int STRIDE_W     = 32;
   localparam int PROD_W       = SIZE_W + STRIDE_W;
   localparam int SUM_W        = PROD_W + 2;
   localparam int OFFSET_W     = 48;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SIZE_DIM0   = 3'd0,
      REG_SIZE_DIM1   = 3'd1,
      REG_SIZE_DIM2   = 3'd2,
      REG_STRIDE_DIM0 = 3'd3,
      REG_STRIDE_DIM1 = 3'd4,
      REG_STRIDE_DIM2 = 3'd5,
      REG_MIRROR_MASK = 3'd6
   } csr_index_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      eff_size = (size == '0) ? SIZE_W'(1) : size;
   endfunction

endpackage

[src/hermitian_mirror_offset_top.sv]
// ----------------------------------------------------------------------------
// hermitian_mirror_offset_top
// Linear index to strided offset with mirrored dimensions, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle; busy is always low. Each result
// appears on rsp_strobe exactly NUM_DIMS*50+1 cycles after its start, in
// order, and must be taken in that cycle. The latency comes from a 48-stage
// bit-per-stage divider per dimension followed by a multiply and an add
// stage, plus one saturation stage. Change the registers only while no
// transaction is in flight.
module hermitian_mirror_offset_top import hmo_pkg::*; #(
   parameter int NUM_DIMS = NUM_DIMS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [INDEX_W-1:0]    req_linear_index,
   output logic                  rsp_strobe,
   output logic [OFFSET_W-1:0]   rsp_element_offset,
   output logic                  rsp_overflow,
   input  logic                  csr_write_enable,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [SIZE_W-1:0]    size_ff   [0:DIM_LIMIT-1];
   logic [STRIDE_W-1:0]  stride_ff [0:DIM_LIMIT-1];
   logic [DIM_LIMIT-1:0] mirror_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM_LIMIT; i++) begin
            size_ff[i]   <= SIZE_W'(1);
            stride_ff[i] <= '0;
         end
         mirror_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SIZE_DIM0:   size_ff[0]   <= csr_write_data[SIZE_W-1:0];
            REG_SIZE_DIM1:   size_ff[1]   <= csr_write_data[SIZE_W-1:0];
            REG_SIZE_DIM2:   size_ff[2]   <= csr_write_data[SIZE_W-1:0];
            REG_STRIDE_DIM0: stride_ff[0] <= csr_write_data;
            REG_STRIDE_DIM1: stride_ff[1] <= csr_write_data;
            REG_STRIDE_DIM2: stride_ff[2] <= csr_write_data;
            REG_MIRROR_MASK: mirror_ff    <= csr_write_data[DIM_LIMIT-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic               dim_valid [0:NUM_DIMS];
   logic [INDEX_W-1:0] dim_rest  [0:NUM_DIMS];
   logic [SUM_W-1:0]   dim_sum   [0:NUM_DIMS];

   assign dim_valid[0] = start;
   assign dim_rest[0]  = req_linear_index;
   assign dim_sum[0]   = '0;

   for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
      logic               div_valid;
      logic [INDEX_W-1:0] div_quo;
      logic [SIZE_W-1:0]  div_rem;
      logic [SUM_W-1:0]   div_sum;
      logic [SIZE_W-1:0]  divisor;
      logic [SIZE_W-1:0]  coord_in;
      logic               mul_valid_ff;
      logic [PROD_W-1:0]  prod_ff;
      logic [INDEX_W-1:0] mul_rest_ff;
      logic [SUM_W-1:0]   mul_sum_ff;
      logic               add_valid_ff;
      logic [INDEX_W-1:0] add_rest_ff;
      logic [SUM_W-1:0]   add_sum_ff;

      assign divisor = eff_size(size_ff[d]);

      hmo_divmod #(
         .DIVIDEND_W (INDEX_W),
         .DIVISOR_W  (SIZE_W),
         .SIDE_W     (SUM_W)
      ) u_divmod (
         .clock         (clock),
         .reset         (reset),
         .in_valid      (dim_valid[d]),
         .in_dividend   (dim_rest[d]),
         .in_side       (dim_sum[d]),
         .divisor       (divisor),
         .out_valid     (div_valid),
         .out_quotient  (div_quo),
         .out_remainder (div_rem),
         .out_side      (div_sum)
      );

      assign coord_in = (mirror_ff[d] && div_rem != '0) ? SIZE_W'(divisor - div_rem)
                                                         : div_rem;

      always_ff @(posedge clock) begin
         if (reset) begin
            mul_valid_ff <= 1'b0;
            add_valid_ff <= 1'b0;
         end else begin
            mul_valid_ff <= div_valid;
            add_valid_ff <= mul_valid_ff;
         end
         prod_ff     <= PROD_W'(coord_in) * PROD_W'(stride_ff[d]);
         mul_rest_ff <= div_quo;
         mul_sum_ff  <= div_sum;
         add_rest_ff <= mul_rest_ff;
         add_sum_ff  <= SUM_W'(mul_sum_ff + SUM_W'(prod_ff));
      end

      assign dim_valid[d+1] = add_valid_ff;
      assign dim_rest[d+1]  = add_rest_ff;
      assign dim_sum[d+1]   = add_sum_ff;
   end

   logic                out_valid_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic                out_ovf_ff;
   logic                ovf_in;

   assign ovf_in = dim_sum[NUM_DIMS][SUM_W-1:OFFSET_W] != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dim_valid[NUM_DIMS];
      end
      out_offset_ff <= ovf_in ? '1 : dim_sum[NUM_DIMS][OFFSET_W-1:0];
      out_ovf_ff    <= ovf_in;
   end

   assign rsp_strobe         = out_valid_ff;
   assign rsp_element_offset = out_offset_ff;
   assign rsp_overflow       = out_ovf_ff;

endmodule

[src/hmo_divmod.sv]
// ----------------------------------------------------------------------------
// hmo_divmod
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module hmo_divmod import hmo_pkg::*; #(
   parameter int DIVIDEND_W = INDEX_W,
   parameter int DIVISOR_W  = SIZE_W,
   parameter int SIDE_W     = SUM_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DIVIDEND_W-1:0] in_dividend,
   input  logic [SIDE_W-1:0]     in_side,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  out_valid,
   output logic [DIVIDEND_W-1:0] out_quotient,
   output logic [DIVISOR_W-1:0]  out_remainder,
   output logic [SIDE_W-1:0]     out_side
);

   logic                  valid_ff [0:DIVIDEND_W];
   logic [DIVIDEND_W-1:0] quo_ff   [0:DIVIDEND_W];
   logic [DIVISOR_W-1:0]  rem_ff   [0:DIVIDEND_W];
   logic [SIDE_W-1:0]     side_ff  [0:DIVIDEND_W];

   assign valid_ff[0] = in_valid;
   assign quo_ff[0]   = in_dividend;
   assign rem_ff[0]   = '0;
   assign side_ff[0]  = in_side;

   for (genvar k = 0; k < DIVIDEND_W; k++) begin : g_stage
      logic [DIVISOR_W:0]    trial;
      logic                  ge;
      logic [DIVISOR_W-1:0]  rem_in;
      logic [DIVIDEND_W-1:0] quo_in;

      always_comb begin
         trial  = {rem_ff[k], quo_ff[k][DIVIDEND_W-1]};
         ge     = trial >= {1'b0, divisor};
         rem_in = ge ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[k][DIVIDEND_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         quo_ff[k+1]  <= quo_in;
         rem_ff[k+1]  <= rem_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid     = valid_ff[DIVIDEND_W];
   assign out_quotient  = quo_ff[DIVIDEND_W];
   assign out_remainder = rem_ff[DIVIDEND_W];
   assign out_side      = side_ff[DIVIDEND_W];

endmodule

[test/tb_hermitian_mirror_offset_top.sv]
// ----------------------------------------------------------------------------
// tb_hermitian_mirror_offset_top
// Self-checking bench for the mirrored strided offset block: a scoreboard
// predicts each offset from its own copy of the registers and checks each
// strobed result in order, over directed cases and random register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hermitian_mirror_offset_top import hmo_pkg::*;;

   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;
   localparam int PIPE_LAT   = NUM_DIMS_DEF * 50 + 1;
   localparam int CYCLE_CAP  = 600000;
   localparam int RAND_ITEMS = 128;
   localparam int PHASES     = 12;

   class offset_scoreboard;
      logic [SIZE_W-1:0]   dim_size   [DIM_LIMIT];
      logic [STRIDE_W-1:0] dim_stride [DIM_LIMIT];
      logic [2:0]          mirror;
      logic [OFFSET_W-1:0] exp_offset [$];
      logic                exp_ovf    [$];
      int                  errors;

      function new();
         foreach (dim_size[d]) begin
            dim_size[d]   = 1;
            dim_stride[d] = 0;
         end
         mirror = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SIZE_DIM0:   dim_size[0] = data[SIZE_W-1:0];
            REG_SIZE_DIM1:   dim_size[1] = data[SIZE_W-1:0];
            REG_SIZE_DIM2:   dim_size[2] = data[SIZE_W-1:0];
            REG_STRIDE_DIM0: dim_stride[0] = data;
            REG_STRIDE_DIM1: dim_stride[1] = data;
            REG_STRIDE_DIM2: dim_stride[2] = data;
            REG_MIRROR_MASK: mirror = data[2:0];
            default: ;
         endcase
      endfunction

      function void note_index(logic [INDEX_W-1:0] idx);
         logic [63:0] rest, sum, sz, coord;
         rest = idx;
         sum  = 0;
         for (int d = 0; d < NUM_DIMS_DEF; d++) begin
            sz    = (dim_size[d] == 0) ? 64'd1 : 64'(dim_size[d]);
            coord = rest % sz;
            rest  = rest / sz;
            if (mirror[d] && coord != 0) coord = sz - coord;
            sum += coord * 64'(dim_stride[d]);
         end
         if (sum > 64'hFFFF_FFFF_FFFF) begin
            exp_offset.push_back('1);
            exp_ovf.push_back(1'b1);
         end else begin
            exp_offset.push_back(sum[OFFSET_W-1:0]);
            exp_ovf.push_back(1'b0);
         end
      endfunction

      function void check_result(logic [OFFSET_W-1:0] offset, logic ovf);
         logic [OFFSET_W-1:0] e_off;
         logic                e_ovf;
         if (exp_offset.size() == 0) begin
            $display("%0t: unexpected transaction offset=%h overflow=%b", $time, offset, ovf);
            errors++;
            return;
         end
         e_off = exp_offset.pop_front();
         e_ovf = exp_ovf.pop_front();
         if (offset !== e_off) begin
            $display("%0t: element_offset expected %h actual %h", $time, e_off, offset);
            errors++;
         end
         if (ovf !== e_ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e_ovf, ovf);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic [INDEX_W-1:0]    req_linear_index = '0;
   logic                  rsp_strobe;
   logic [OFFSET_W-1:0]   rsp_element_offset;
   logic                  rsp_overflow;
   logic                  csr_write_enable = 0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   offset_scoreboard sb = new();
   int cycles = 0;
   int idle_pct = 0;

   hermitian_mirror_offset_top uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("tb_hermitian_mirror_offset_top: done, errors");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) sb.note_index(req_linear_index);
         if (rsp_strobe) sb.check_result(rsp_element_offset, rsp_overflow);
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic load_regs(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                            logic [31:0] t0, logic [31:0] t1, logic [31:0] t2,
                            logic [31:0] m);
      write_reg(REG_SIZE_DIM0, s0);
      write_reg(REG_SIZE_DIM1, s1);
      write_reg(REG_SIZE_DIM2, s2);
      write_reg(REG_STRIDE_DIM0, t0);
      write_reg(REG_STRIDE_DIM1, t1);
      write_reg(REG_STRIDE_DIM2, t2);
      write_reg(REG_MIRROR_MASK, m);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_index(logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_linear_index <= idx;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.exp_offset.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_size();
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return $urandom_range(2, 9);
         3: return $urandom_range(10, 300);
         4: return 32'h1FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_stride();
      case ($urandom_range(3))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 1000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      logic [63:0] span;
      span = 64'(sb.dim_size[0]) * 64'(sb.dim_size[1]) * 64'(sb.dim_size[2]);
      case ($urandom_range(3))
         0: return INDEX_W'({$urandom(), $urandom()});
         1: return INDEX_W'({$urandom(), $urandom()} % (span + 1));
         2: return INDEX_W'($urandom_range(0, 20));
         default: return ~INDEX_W'($urandom_range(0, 20));
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_regs(3, 4, 5, 1, 10, 100, 5);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      send_index(0);  send_index(1);  send_index(2);  send_index(3);
      send_index(11); send_index(12); send_index(59); send_index(60);
      send_index(61); send_index('1); send_index(48'h8000_0000_0000);
      drain();

      load_regs(32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 7);
      send_index(0); send_index(1); send_index('1); send_index(48'h1_FFFE_0001);
      drain();

      load_regs(0, 65536, 0, 7, 32'hFFFF_FFFF, 3, 2);
      send_index(0); send_index(65535); send_index(65536); send_index('1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: idle_pct = 0;
            1: idle_pct = 53;
            2: idle_pct = 8;
            default: idle_pct = $urandom_range(0, 30);
         endcase
         load_regs(pick_size(), pick_size(), pick_size(), pick_stride(), pick_stride(),
                   pick_stride(), $urandom());
         for (int i = 0; i < RAND_ITEMS; i++) send_index(pick_index());
         drain();
      end

      if (sb.errors == 0 && sb.exp_offset.size() == 0)
         $display("tb_hermitian_mirror_offset_top: done, clean");
      else
         $display("tb_hermitian_mirror_offset_top: done, errors");
      $finish;
   end

endmodule

[hermitian_mirror_offset_top.f]
src/hmo_pkg.sv
src/hmo_divmod.sv
src/hermitian_mirror_offset_top.sv
test/tb_hermitian_mirror_offset_top.sv
